// ===== rtl/rcf_pkg.sv =====
`default_nettype none
package rcf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int TAPS     = 9;
   localparam int PIX_W    = 32;
   localparam int PROD_W   = 17;
   localparam int SUM_W    = 21;
   localparam int MAG_W    = 19;
   localparam int DIV_W    = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_UPPER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_LOWER = 3'd4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/rcf_ram.sv =====
`default_nettype none
module rcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/rcf_lane.sv =====
`default_nettype none
module rcf_lane
   import rcf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [8*TAPS-1:0]  pix,
   input  wire logic [8*TAPS-1:0]  coef,
   input  wire logic [DIV_W-1:0]   divisor,
   output logic                    done,
   output logic [7:0]              value
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_SUM  = 2'd1;
   localparam logic [1:0] L_DIV  = 2'd2;
   localparam logic [1:0] L_FIN  = 2'd3;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic [1:0]              ph_ff, ph_in;
   logic signed [PROD_W-1:0] prod_ff [TAPS];
   logic signed [PROD_W-1:0] prod_in [TAPS];
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        quo_ff, quo_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        mag;
   logic [DIV_W-1:0]        dsel;
   logic [DIV_W:0]          shifted;

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod_in[k] = PROD_W'($signed({1'b0, pix[8*k +: 8]}) * $signed(coef[8*k +: 8]));
      end
      sum = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum = sum + SUM_W'(prod_ff[k]);
      end
      mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      dsel    = (divisor == '0) ? DIV_W'(1) : divisor;
      shifted = {rem_ff, quo_ff[MAG_W-1]};
   end

   always_comb begin
      ph_in  = ph_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      unique case (ph_ff)
         L_IDLE: begin
            if (start) begin
               ph_in = L_SUM;
            end
         end
         L_SUM: begin
            neg_in = sum[SUM_W-1];
            quo_in = mag[MAG_W-1:0];
            rem_in = '0;
            cnt_in = CNT_W'(MAG_W);
            ph_in  = L_DIV;
         end
         L_DIV: begin
            if (shifted >= {1'b0, dsel}) begin
               rem_in = DIV_W'(shifted - {1'b0, dsel});
               quo_in = {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIV_W-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               ph_in = L_FIN;
            end
         end
         L_FIN: begin
            ph_in = L_IDLE;
         end
         default: ph_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= L_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
      if (start && ph_ff == L_IDLE) begin
         prod_ff <= prod_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done  = (ph_ff == L_FIN);
   assign value = (neg_ff || quo_ff == '0) ? 8'd0 :
                  (quo_ff > MAG_W'(255)) ? 8'd255 : quo_ff[7:0];

endmodule
`default_nettype wire

// ===== rtl/rgb_conv3x3_filter.sv =====
`default_nettype none
// 3x3 convolution on a raster-order RGBA stream. A result waits in S_HOLD
// until the output is free, and that of an interior pixel first waits in
// S_GO and S_WAIT for the three channel lanes, each running
// a one-bit-per-cycle divider over a 19-bit magnitude. Results come out one
// row plus one pixel after their input; drain items flush the last row.
module rgb_conv3x3_filter
   import rcf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [7:0]            req_in_red,
   input  wire logic [7:0]            req_in_green,
   input  wire logic [7:0]            req_in_blue,
   input  wire logic [7:0]            req_in_alpha,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic [7:0]                 rsp_out_alpha,
   output logic                       rsp_last_of_frame,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = $clog2(MAX_WIDTH + 2);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_BRD  = 3'd2;
   localparam logic [2:0] S_GO   = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_HOLD = 3'd5;

   logic [10:0] fw_ff;
   logic [12:0] fh_ff;
   logic [DIV_W-1:0] div_ff;
   logic [47:0] kup_ff;
   logic [23:0] kbot_ff;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [CW-1:0] ic_ff;
   logic [RW-1:0] ir_ff;
   logic [PIX_W-1:0] px_ff;
   logic        last_ff;
   logic [PIX_W-1:0] win_ff [TAPS];
   logic [PIX_W-1:0] win_in [TAPS];
   result_type  res_ff, res_in;
   result_type  rsp_ff;
   logic        rsp_valid_ff;

   logic [31:0] w32, h32, c0, r0;
   logic        accept, drain, act;
   logic [PIX_W-1:0] up_q, lo_q;
   logic [CW-1:0] up_raddr;
   logic        wr_en;
   logic [8*TAPS-1:0] coefs;
   logic [8*TAPS-1:0] lane_pix [3];
   logic [2:0]  lane_done;
   logic [7:0]  lane_val [3];
   logic        border, centre_out, interior;

   always_comb begin
      w32 = (32'(fw_ff) < 32'd3) ? 32'd3 :
            (32'(fw_ff) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(fw_ff);
      h32 = (32'(fh_ff) < 32'd3) ? 32'd3 :
            (32'(fh_ff) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(fh_ff);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign drain     = req_mode;
   assign act       = !drain || pend_ff != '0;

   always_comb begin
      c0 = (!drain && pend_ff != '0) ? 32'd0 : 32'(col_ff);
      r0 = (!drain && pend_ff != '0) ? 32'd0 : 32'(row_ff);
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (accept && act) begin
         if (drain) begin
            pend_in = pend_ff - 1'b1;
            col_in  = (c0 + 32'd1 >= w32) ? '0 : CW'(c0 + 32'd1);
            if (pend_ff == PW'(1)) begin
               col_in = '0;
               row_in = '0;
            end
         end else begin
            pend_in = '0;
            row_in  = RW'(r0);
            col_in  = CW'(c0 + 32'd1);
            if (c0 + 32'd1 >= w32) begin
               col_in = '0;
               if (r0 + 32'd1 >= h32) begin
                  row_in  = RW'(h32);
                  pend_in = PW'(w32 + 32'd1);
               end else begin
                  row_in = RW'(r0 + 32'd1);
               end
            end
         end
      end
   end

   assign up_raddr = (state_ff == S_RD) ? CW'(w32 - 32'd1) : CW'(c0);
   assign wr_en    = (state_ff == S_RD);

   rcf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ic_ff),
      .wr_data (lo_q),
      .rd_addr (up_raddr),
      .rd_data (up_q)
   );

   rcf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ic_ff),
      .wr_data (px_ff),
      .rd_addr (CW'(c0)),
      .rd_data (lo_q)
   );

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = up_q;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = lo_q;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = px_ff;
   end

   assign border     = (ic_ff == '0) && (32'(ir_ff) >= 32'd2);
   assign centre_out = (ic_ff != '0) && (ir_ff != '0);
   assign interior   = (32'(ic_ff) >= 32'd2) && (32'(ic_ff) < w32) &&
                       (32'(ir_ff) >= 32'd2) && (32'(ir_ff) < h32);

   assign coefs = {kbot_ff, kup_ff};

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         for (int k = 0; k < TAPS; k++) begin
            lane_pix[l][8*k +: 8] = win_ff[k][8*l +: 8];
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      rcf_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (state_ff == S_GO),
         .pix     (lane_pix[l]),
         .coef    (coefs),
         .divisor (div_ff),
         .done    (lane_done[l]),
         .value   (lane_val[l])
      );
   end

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && act) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (border) begin
               state_in = S_BRD;
            end else if (centre_out && interior) begin
               state_in = S_GO;
            end else if (centre_out) begin
               res_in   = '{red: win_in[4][7:0], green: win_in[4][15:8],
                            blue: win_in[4][23:16], alpha: win_in[4][31:24],
                            last: last_ff};
               state_in = S_HOLD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_BRD: begin
            res_in   = '{red: up_q[7:0], green: up_q[15:8], blue: up_q[23:16],
                         alpha: up_q[31:24], last: last_ff};
            state_in = S_HOLD;
         end
         S_GO: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (lane_done[0]) begin
               res_in   = '{red: lane_val[0], green: lane_val[1], blue: lane_val[2],
                            alpha: win_ff[4][31:24], last: last_ff};
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= 11'd640;
         fh_ff        <= 13'd360;
         div_ff       <= DIV_W'(1);
         kup_ff       <= 48'h0001_0000_0000;
         kbot_ff      <= '0;
         for (int k = 0; k < TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         if (state_ff == S_RD) begin
            win_ff <= win_in;
         end
         if (state_ff == S_HOLD && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff   <= csr_data[10:0];
               CSR_FRAME_HEIGHT: fh_ff   <= csr_data[12:0];
               CSR_DIVISOR:      div_ff  <= csr_data[DIV_W-1:0];
               CSR_KERNEL_UPPER: kup_ff  <= csr_data;
               CSR_KERNEL_LOWER: kbot_ff <= csr_data[23:0];
               default: ;
            endcase
         end
      end
      if (accept) begin
         ic_ff   <= CW'(c0);
         ir_ff   <= RW'(r0);
         px_ff   <= drain ? '0 : {req_in_alpha, req_in_blue, req_in_green, req_in_red};
         last_ff <= drain && pend_ff == PW'(1);
      end
      res_ff <= res_in;
      if (state_ff == S_HOLD && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_red       = rsp_ff.red;
   assign rsp_out_green     = rsp_ff.green;
   assign rsp_out_blue      = rsp_ff.blue;
   assign rsp_out_alpha     = rsp_ff.alpha;
   assign rsp_last_of_frame = rsp_ff.last;

   a_go_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GO |=> state_ff == S_WAIT)
      else $error("lane start not followed by wait");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> state_ff == S_WAIT)
      else $error("lane finished outside wait");
   a_rd_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |=> state_ff != S_RD && state_ff != S_IDLE || $past(!border
      && !centre_out))
      else $error("line store step repeated");
   a_lanes_lock: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> lane_done[1] && lane_done[2])
      else $error("lanes out of step");

endmodule
`default_nettype wire

// ===== verif/rgb_conv3x3_filter_tb.sv =====
`timescale 1ns / 100ps
module rgb_conv3x3_filter_tb;
   import rcf_pkg::*;

   localparam int MAXW = 1024;
   localparam int MAXH = 4096;

   class conv_scoreboard;
      logic [10:0] width_reg;
      logic [12:0] height_reg;
      logic [10:0] div_reg;
      logic [47:0] kup_reg;
      logic [23:0] kbot_reg;
      logic [31:0] upper_line [MAXW];
      logic [31:0] lower_line [MAXW];
      logic [31:0] win [9];
      int unsigned col, row, pending;
      result_type pixel_q[$];
      int mismatches;
      int results_seen;

      function new();
         width_reg = 640;
         height_reg = 360;
         div_reg = 1;
         kup_reg = 48'h0001_0000_0000;
         kbot_reg = 0;
         foreach (upper_line[i]) begin
            upper_line[i] = 0;
            lower_line[i] = 0;
         end
         foreach (win[i]) win[i] = 0;
         col = 0;
         row = 0;
         pending = 0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            CSR_FRAME_WIDTH:  width_reg = d[10:0];
            CSR_FRAME_HEIGHT: height_reg = d[12:0];
            CSR_DIVISOR:      div_reg = d[10:0];
            CSR_KERNEL_UPPER: kup_reg = d[47:0];
            CSR_KERNEL_LOWER: kbot_reg = d[23:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_w();
         if (width_reg < 3) return 3;
         if (width_reg > MAXW) return MAXW;
         return width_reg;
      endfunction

      function int unsigned eff_h();
         if (height_reg < 3) return 3;
         if (height_reg > MAXH) return MAXH;
         return height_reg;
      endfunction

      function int tap(int k);
         logic signed [7:0] b;
         if (k < 6) b = kup_reg[8*k +: 8];
         else b = kbot_reg[8*(k-6) +: 8];
         return int'(b);
      endfunction

      function logic [7:0] weigh(int sh);
         int sum, q, d;
         sum = 0;
         for (int k = 0; k < 9; k++) sum += int'(win[k][sh +: 8]) * tap(k);
         d = (div_reg == 0) ? 1 : int'(div_reg);
         q = sum / d;
         if (q > 255) q = 255;
         if (q < 0) q = 0;
         return q[7:0];
      endfunction

      function void emit(logic [31:0] px, bit last);
         result_type r;
         r.red = px[7:0];
         r.green = px[15:8];
         r.blue = px[23:16];
         r.alpha = px[31:24];
         r.last = last;
         pixel_q.push_back(r);
      endfunction

      function void shift_in(logic [31:0] px, bit last);
         int unsigned w, h, ci;
         logic [31:0] ctr;
         w = eff_w();
         h = eff_h();
         ci = (col < MAXW) ? col : 0;
         if (col == 0 && row >= 2) emit(upper_line[w-1], last);
         for (int r = 0; r < 3; r++) begin
            win[3*r] = win[3*r+1];
            win[3*r+1] = win[3*r+2];
         end
         win[2] = upper_line[ci];
         win[5] = lower_line[ci];
         win[8] = px;
         upper_line[ci] = lower_line[ci];
         lower_line[ci] = px;
         if (col >= 1 && row >= 1) begin
            ctr = win[4];
            if (col >= 2 && col - 1 <= w - 2 && row >= 2 && row - 1 <= h - 2)
               ctr = {ctr[31:24], weigh(16), weigh(8), weigh(0)};
            emit(ctr, last);
         end
      endfunction

      function void note_input(bit mode, logic [31:0] px);
         int unsigned w, h;
         w = eff_w();
         h = eff_h();
         if (mode) begin
            if (pending == 0) return;
            shift_in(0, pending == 1);
            pending--;
            col++;
            if (col >= w) col = 0;
            if (pending == 0) begin
               col = 0;
               row = 0;
            end
            return;
         end
         if (pending != 0) begin
            pending = 0;
            col = 0;
            row = 0;
         end
         shift_in(px, 0);
         col++;
         if (col >= w) begin
            col = 0;
            if (row + 1 >= h) begin
               row = h;
               pending = w + 1;
            end else begin
               row++;
            end
         end
      endfunction

      function void check_result(result_type got);
         result_type exp;
         results_seen++;
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         exp = pixel_q.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected r%h g%h b%h a%h l%b, got r%h g%h b%h a%h l%b",
                  exp.red, exp.green, exp.blue, exp.alpha, exp.last,
                  got.red, got.green, got.blue, got.alpha, got.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_mode = 0;
   logic [7:0] req_in_red = 0, req_in_green = 0, req_in_blue = 0, req_in_alpha = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic rsp_last_of_frame;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   conv_scoreboard sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int pixels_sent = 0;
   int frames_run = 0;

   rgb_conv3x3_filter DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
            rsp_last_of_frame});
      if (reset) rsp_ready <= 0;
      else if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_item(bit mode, logic [31:0] px);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      {req_in_alpha, req_in_blue, req_in_green, req_in_red} <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(mode, px);
      if (!mode) pixels_sent++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, d);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 0;
      while (sb.pixel_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_px();
      return $urandom;
   endfunction

   // full frame of w x h pixels then drains
   task automatic run_frame(int w, int h, int sel);
      logic [31:0] px;
      for (int i = 0; i < w * h; i++) begin
         case (sel)
            0: px = rand_px();
            1: px = (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: px = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : rand_px();
         endcase
         send_item(0, px);
      end
      for (int i = 0; i < w + 1; i++) send_item(1, rand_px());
      frames_run++;
   endtask

   task automatic set_geometry(int w, int h, int dv, logic [47:0] ku, logic [23:0] kb);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_DIVISOR, dv);
      write_csr(CSR_KERNEL_UPPER, ku);
      write_csr(CSR_KERNEL_LOWER, kb);
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tiny frame, identity kernel, drains with nothing pending
      set_geometry(3, 3, 1, 48'h0001_0000_0000, 24'h0);
      send_item(1, 32'h1234_5678);
      run_frame(3, 3, 1);
      send_item(1, 0);
      settle();
      // all-positive kernel, max divisor, then all negative
      set_geometry(4, 3, 2047, 48'h7F7F_7F7F_7F7F, 24'h7F7F7F);
      run_frame(4, 3, 1);
      settle();
      set_geometry(3, 4, 0, 48'h8080_8080_8080, 24'h808080);
      run_frame(3, 4, 0);
      settle();
      // width and height registers below minimum
      set_geometry(0, 0, 1, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF);
      run_frame(3, 3, 2);
      settle();
      // pixel arriving while flush pending restarts the frame
      set_geometry(5, 3, 3, 48'h01FF_0102_0304, 24'hFE0201);
      for (int i = 0; i < 15; i++) send_item(0, rand_px());
      send_item(1, 0);
      send_item(1, 0);
      run_frame(5, 3, 0);
      settle();
      write_csr(CSR_FRAME_WIDTH, 11'h7FF);
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
      write_csr(CSR_FRAME_WIDTH, 5);
      write_csr(CSR_FRAME_HEIGHT, 3);
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if (ph == 0) hold_cycles = 400;
         while (pixels_sent < 75 + 150 * (ph + 1)) begin
            int w, h;
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 6);
            set_geometry(w, h, $urandom_range(0, 2047) % ($urandom_range(1) ? 2048 : 40),
               {$urandom, $urandom}, $urandom);
            if ($urandom_range(9) == 0) begin
               int cut;
               // broken frame: a drain mid-frame, a short flush, then restart
               cut = $urandom_range(1, w);
               for (int i = 0; i < w * h - cut; i++)
                  send_item(0, rand_px());
               send_item(1, rand_px());
               for (int i = 0; i < cut; i++)
                  send_item(0, rand_px());
               send_item(1, rand_px());
               send_item(1, rand_px());
               run_frame(w, h, $urandom_range(2));
            end else begin
               run_frame(w, h, $urandom_range(2));
            end
            settle();
         end
      end
      // one wider frame
      send_idle_pct = 0;
      recv_stall_pct = 10;
      set_geometry(128, 3, 9, 48'h0102_0100_0102, 24'h010201);
      run_frame(128, 3, 0);
      settle();

      $display("covered %0d frames, %0d pixels, %0d results checked",
         frames_run, pixels_sent, sb.results_seen);
      if (sb.mismatches == 0 && sb.pixel_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rcf_pkg.sv
rtl/rcf_ram.sv
rtl/rcf_lane.sv
rtl/rgb_conv3x3_filter.sv
verif/rgb_conv3x3_filter_tb.sv
